// ----- sv/wph_pkg.sv -----
// Shared types and constants for the word polynomial id hash.
// Holds the payload structs, the configuration register codes and the fixed field widths.
// No dependencies.
package wph_pkg;

	localparam int ID_W       = 36;
	localparam int IDX_W      = 12;
	localparam int ALPHA_W    = 13;
	localparam int OFFS_W     = 16;
	localparam int FACT_W     = OFFS_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(53);
	localparam logic [OFFS_W-1:0]  OFFS_RESET  = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHABET_SIZE = 2'd0,
		REG_LETTER_OFFSET = 2'd1
	} cfg_reg_e;

	typedef struct packed {
		logic [IDX_W-1:0] letter_index;
		logic             letter_found;
		logic             last_letter;
	} letter_t;

	typedef struct packed {
		logic [ID_W-1:0] word_id;
		logic            no_id;
	} word_id_t;

	// control of the term register between the two stages
	typedef struct packed {
		logic valid;
		logic last;
	} term_ctl_t;

endpackage

// ----- sv/wph_mersenne_fold.sv -----
// Combinational residue of a value modulo 2^K - 1.
// Adds the K-bit chunks, then folds the carry bits back a few times.
// Depends on nothing.
module wph_mersenne_fold #(
	parameter int K    = 36,
	parameter int IN_W = 59
) (
	input  logic [IN_W-1:0] value,
	output logic [K-1:0]    residue
);

	localparam int NCH   = (IN_W + K - 1) / K;
	localparam int SUM_W = K + $clog2(NCH) + 1;
	localparam int NF    = $clog2(NCH) + 3;
	localparam logic [K-1:0] MODULUS = '1;

	logic [NCH*K-1:0] padded;

	assign padded = (NCH*K)'(value);

	always_comb begin
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < NCH; i++) begin
			acc = acc + SUM_W'(padded[i*K +: K]);
		end
		// end-around carry folds; value settles below 2^K
		for (int j = 0; j < NF; j++) begin
			acc = SUM_W'(acc[K-1:0]) + (acc >> K);
		end
		residue = (acc[K-1:0] == MODULUS) ? '0 : acc[K-1:0];
	end

endmodule

// ----- sv/wph_term_stage.sv -----
// Letter input register, power sequence and letter count, and the weighted term register.
// Depends on wph_pkg and wph_mersenne_fold.
module wph_term_stage #(
	parameter int MAX_LEN = 35,
	parameter int TERM_W  = 53
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         letter_valid,
	output logic                         letter_ready,
	input  wph_pkg::letter_t             letter,
	input  logic [wph_pkg::ALPHA_W-1:0]  alphabet_size,
	input  logic [wph_pkg::OFFS_W-1:0]   letter_offset,
	input  logic                         term_ready,
	output wph_pkg::term_ctl_t           term_ctl,
	output logic [TERM_W-1:0]            term
);

	localparam int K     = MAX_LEN + 1;
	localparam int PW    = (K < wph_pkg::ID_W) ? K : wph_pkg::ID_W;
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int PP_W  = PW + wph_pkg::ALPHA_W;

	logic                         valid_s1;
	wph_pkg::letter_t             item_s1;
	logic [PW-1:0]                power_q;
	logic [CNT_W-1:0]             count_q;
	wph_pkg::term_ctl_t           ctl_s2;
	logic [TERM_W-1:0]            term_s2;

	logic                         s2_free;
	logic                         s1_go;
	logic                         counting;
	logic [PP_W-1:0]              pow_prod;
	logic [K-1:0]                 pow_res;
	logic [wph_pkg::FACT_W-1:0]   factor;
	logic [TERM_W-1:0]            term_next;

	assign s2_free      = !ctl_s2.valid || term_ready;
	assign s1_go        = valid_s1 && s2_free;
	assign letter_ready = !valid_s1 || s2_free;
	assign counting     = count_q < CNT_W'(MAX_LEN);

	assign pow_prod = PP_W'(power_q) * PP_W'(alphabet_size);

	wph_mersenne_fold #(
		.K    (K),
		.IN_W (PP_W)
	) u_pow_fold (
		.value   (pow_prod),
		.residue (pow_res)
	);

	assign factor = wph_pkg::FACT_W'(item_s1.letter_index) + wph_pkg::FACT_W'(letter_offset);
	assign term_next = (counting && item_s1.letter_found)
		? TERM_W'(power_q) * TERM_W'(factor) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			power_q  <= PW'(1);
			count_q  <= '0;
			ctl_s2   <= '0;
		end else begin
			if (letter_ready) begin
				valid_s1 <= letter_valid;
			end
			if (s1_go) begin
				if (item_s1.last_letter) begin
					power_q <= PW'(1);
					count_q <= '0;
				end else if (counting) begin
					power_q <= PW'(pow_res);
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (s2_free) begin
				ctl_s2.valid <= valid_s1;
				ctl_s2.last  <= item_s1.last_letter;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (letter_valid && letter_ready) begin
			item_s1 <= letter;
		end
		if (s2_free) begin
			term_s2 <= term_next;
		end
	end

	assign term_ctl = ctl_s2;
	assign term     = term_s2;

endmodule

// ----- sv/wph_accum_stage.sv -----
// Running word sum, final sum register, Mersenne reduction and the result register.
// Depends on wph_pkg and wph_mersenne_fold.
module wph_accum_stage #(
	parameter int MAX_LEN = 35,
	parameter int TERM_W  = 53
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wph_pkg::term_ctl_t  term_ctl,
	input  logic [TERM_W-1:0]   term,
	output logic                term_ready,
	output logic                id_valid,
	input  logic                id_ready,
	output wph_pkg::word_id_t   id
);

	localparam int K     = MAX_LEN + 1;
	localparam int SUM_W = TERM_W + $clog2(MAX_LEN + 1);

	logic [SUM_W-1:0]   acc_q;
	logic               valid_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic               id_valid_q;
	wph_pkg::word_id_t  id_q;

	logic               out_free;
	logic               s3_go;
	logic               s3_free;
	logic               s2_go;
	logic [SUM_W-1:0]   sum_next;
	logic [K-1:0]       sum_res;

	assign out_free   = !id_valid_q || id_ready;
	assign s3_go      = valid_s3 && out_free;
	assign s3_free    = !valid_s3 || out_free;
	assign term_ready = !(term_ctl.valid && term_ctl.last) || s3_free;
	assign s2_go      = term_ctl.valid && term_ready;
	assign sum_next   = acc_q + SUM_W'(term);

	wph_mersenne_fold #(
		.K    (K),
		.IN_W (SUM_W)
	) u_sum_fold (
		.value   (sum_s3),
		.residue (sum_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			valid_s3   <= 1'b0;
			id_valid_q <= 1'b0;
		end else begin
			if (s2_go) begin
				acc_q <= term_ctl.last ? '0 : sum_next;
			end
			if (s3_free) begin
				valid_s3 <= s2_go && term_ctl.last;
			end
			if (out_free) begin
				id_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && s2_go && term_ctl.last) begin
			sum_s3 <= sum_next;
		end
		if (s3_go) begin
			id_q.word_id <= wph_pkg::ID_W'(sum_res);
			id_q.no_id   <= (sum_s3 == '0);
		end
	end

	assign id_valid = id_valid_q;
	assign id       = id_q;

endmodule

// ----- sv/word_polynomial_id_hash.sv -----
// Word polynomial id hash, top level: configuration registers and the two stages.
// Depends on wph_pkg, wph_term_stage and wph_accum_stage.
//
// Use: letters of a word enter on the letter channel (letter_valid/letter_ready), one
// transaction per letter, each carrying its alphabet position, a found flag and a last flag.
// Only a letter flagged last yields a transaction on the id channel (id_valid/id_ready):
// the weighted sum modulo 2^(MAX_LEN+1)-1, or no_id when the sum is zero.
// Letters past MAX_LEN still end a word when flagged last but add nothing.
// Throughput: one letter per cycle while letter_ready is high; the power
// recurrence (power times alphabet_size, then a Mersenne fold) closes on itself through
// the power register alone, which sets that rate. After the last letter is accepted, the id
// passes the input register, term register, sum register and result register.
// Configuration: cfg_valid/cfg_index/cfg_data write alphabet_size (index 0) and
// letter_offset (index 1); cfg_ready is always high. Write only while no word is in flight.
// Reset: alphabet_size 53, letter_offset 0, word state cleared, all stages empty.
// Stall: when id_ready is low the finished id holds, one more word can finish into the
// sum register, and letters keep flowing until a third last letter waits in the term
// register and the input register behind it fills; letter_ready drops only then.
module word_polynomial_id_hash #(
	parameter int MAX_LEN = 35
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             letter_valid,
	output logic                             letter_ready,
	input  wph_pkg::letter_t                 letter,
	output logic                             id_valid,
	input  logic                             id_ready,
	output wph_pkg::word_id_t                id,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wph_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wph_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int K      = MAX_LEN + 1;
	localparam int PW     = (K < wph_pkg::ID_W) ? K : wph_pkg::ID_W;
	localparam int TERM_W = PW + wph_pkg::FACT_W;

	logic [wph_pkg::ALPHA_W-1:0]  alphabet_size_q;
	logic [wph_pkg::OFFS_W-1:0]   letter_offset_q;
	wph_pkg::term_ctl_t           term_ctl;
	logic [TERM_W-1:0]            term;
	logic                         term_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_size_q <= wph_pkg::ALPHA_RESET;
			letter_offset_q <= wph_pkg::OFFS_RESET;
		end else if (cfg_valid) begin
			unique case (wph_pkg::cfg_reg_e'(cfg_index))
				wph_pkg::REG_ALPHABET_SIZE: begin
					alphabet_size_q <= wph_pkg::ALPHA_W'(cfg_data);
				end
				wph_pkg::REG_LETTER_OFFSET: begin
					letter_offset_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	wph_term_stage #(
		.MAX_LEN (MAX_LEN),
		.TERM_W  (TERM_W)
	) u_term (
		.clk           (clk),
		.arst_n        (arst_n),
		.letter_valid  (letter_valid),
		.letter_ready  (letter_ready),
		.letter        (letter),
		.alphabet_size (alphabet_size_q),
		.letter_offset (letter_offset_q),
		.term_ready    (term_ready),
		.term_ctl      (term_ctl),
		.term          (term)
	);

	wph_accum_stage #(
		.MAX_LEN (MAX_LEN),
		.TERM_W  (TERM_W)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_ctl   (term_ctl),
		.term       (term),
		.term_ready (term_ready),
		.id_valid   (id_valid),
		.id_ready   (id_ready),
		.id         (id)
	);

	// back-pressure on letters only ever comes from a stalled result
	a_letter_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!letter_ready |-> (id_valid && !id_ready))
		else $error("letter channel stalled without a stalled result");

	// the accumulator only refuses a finished word
	a_term_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!term_ready |-> (term_ctl.valid && term_ctl.last))
		else $error("term stage stalled on a non-final letter");

	a_no_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(id_valid && id.no_id) |-> (id.word_id == '0))
		else $error("no_id result with nonzero word_id");

endmodule
